// ----- rtl/boris_particle_push_assert.svh -----
// Assertion macros for the Boris particle push block.
// Used by the top level; depends on nothing else.
`ifndef BORIS_PARTICLE_PUSH_ASSERT_SVH
`define BORIS_PARTICLE_PUSH_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define BPP_ASSERT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is low.
`define BPP_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- rtl/bpp_pkg.sv -----
// Shared types and constants for the Boris particle push block.
// No dependencies; used by the channel interfaces, the top level and the testbench.
`default_nettype none

package bpp_pkg;

  localparam int unsigned FIELD_W   = 32;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DT_W  = 31;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_QM = 2'd0,
    CFG_DT = 2'd1
  } cfg_idx_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] vel_x;
    logic signed [FIELD_W-1:0] vel_y;
    logic signed [FIELD_W-1:0] vel_z;
    logic signed [FIELD_W-1:0] pos_x;
    logic signed [FIELD_W-1:0] pos_y;
    logic signed [FIELD_W-1:0] pos_z;
    logic signed [FIELD_W-1:0] efield_x;
    logic signed [FIELD_W-1:0] efield_y;
    logic signed [FIELD_W-1:0] efield_z;
    logic signed [FIELD_W-1:0] bfield_x;
    logic signed [FIELD_W-1:0] bfield_y;
    logic signed [FIELD_W-1:0] bfield_z;
  } in_item_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] new_vel_x;
    logic signed [FIELD_W-1:0] new_vel_y;
    logic signed [FIELD_W-1:0] new_vel_z;
    logic signed [FIELD_W-1:0] new_pos_x;
    logic signed [FIELD_W-1:0] new_pos_y;
    logic signed [FIELD_W-1:0] new_pos_z;
    logic                      saturated;
  } out_item_t;

endpackage

`default_nettype wire

// ----- rtl/bpp_ifs.sv -----
// Valid/ready channel interfaces: particle input, result output, register writes.
// Depends on bpp_pkg for the payload types.
`default_nettype none

interface bpp_in_if;
  logic             valid;
  logic             ready;
  bpp_pkg::in_item_t item;
  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

interface bpp_out_if;
  logic              valid;
  logic              ready;
  bpp_pkg::out_item_t item;
  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

interface bpp_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [bpp_pkg::CFG_IDX_W-1:0]   idx;
  logic [bpp_pkg::FIELD_W-1:0]     data;
  modport source (output valid, output idx, output data, input ready);
  modport sink   (input valid, input idx, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/boris_particle_push.sv -----
// Boris particle push, fully pipelined: one particle per cycle unless an output
// stall or a register write holds the input. The pipelined divider that forms
// 2/(1+|t|^2) has FRAC_BITS + 2 bit stages. A register write holds off new
// input while a write is offered and while its hold flag is set, as the
// coefficient 0.5*(q/m)*dt is re-formed. Output stalls freeze the whole pipe.
// Depends on bpp_pkg, the channel interfaces and the assertion header.
`default_nettype none

`include "boris_particle_push_assert.svh"

module boris_particle_push #(
  parameter int unsigned WORD_WIDTH = 32,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  bpp_in_if.sink     in_ch,
  bpp_out_if.source  out_ch,
  bpp_cfg_if.sink    cfg_ch
);

  localparam int unsigned W  = WORD_WIDTH;
  localparam int unsigned F  = FRAC_BITS;
  localparam int unsigned AW = (W > 32) ? W : 32;
  localparam int unsigned PW = 2 * AW + 1;
  localparam int unsigned QW = F + 2;
  localparam int unsigned DW = W + 2 * F + 4;
  localparam int unsigned D  = QW + 11;
  localparam int unsigned CW = $clog2(D + 1);
  localparam logic signed [63:0] WHI = (64'sd1 <<< (W - 1)) - 64'sd1;
  localparam logic signed [63:0] WLO = -WHI - 64'sd1;
  localparam logic signed [63:0] OHI = 64'sd2147483647;
  localparam logic signed [63:0] OLO = -OHI - 64'sd1;

  typedef logic [2:0][W-1:0] vec_t;

  typedef struct packed {
    vec_t          v;
    vec_t          pos;
    vec_t          ek;
    vec_t          tv;
    vec_t          vp;
    vec_t          s;
    vec_t          pa;
    vec_t          pb;
    logic [W-1:0]  tt;
    logic [W-1:0]  f;
    logic [DW-1:0] rem;
    logic [DW-1:0] den;
    logic [QW-1:0] quo;
    logic          sat;
  } rec_t;

  typedef struct packed {
    logic         fl;
    logic [W-1:0] val;
  } res_t;

  typedef struct packed {
    logic                           fl;
    logic [bpp_pkg::FIELD_W-1:0]    val;
  } ores_t;

  function automatic logic signed [AW-1:0] ax(input logic [W-1:0] x);
    return AW'($signed(x));
  endfunction

  function automatic logic signed [63:0] sx(input logic [W-1:0] x);
    return 64'($signed(x));
  endfunction

  function automatic res_t clampw(input logic signed [63:0] x);
    res_t r;
    r.fl  = (x > WHI) || (x < WLO);
    r.val = (x > WHI) ? W'(WHI) : ((x < WLO) ? W'(WLO) : W'(x));
    return r;
  endfunction

  function automatic ores_t clamp32(input logic [W-1:0] x);
    ores_t r;
    logic signed [63:0] y;
    y     = sx(x);
    r.fl  = (y > OHI) || (y < OLO);
    r.val = (y > OHI) ? 32'(OHI) : ((y < OLO) ? 32'(OLO) : 32'(y));
    return r;
  endfunction

  // Rounded (ties away from zero), shifted and saturated product.
  function automatic res_t fm(input logic signed [AW-1:0] a, input logic signed [AW-1:0] b,
                              input int unsigned sh);
    res_t r;
    logic neg;
    logic [AW-1:0] ma, mb;
    logic [PW-1:0] pr, m, lim;
    neg = a[AW-1] ^ b[AW-1];
    ma  = a[AW-1] ? AW'(-a) : AW'(a);
    mb  = b[AW-1] ? AW'(-b) : AW'(b);
    pr  = PW'(ma) * PW'(mb);
    m   = (pr + (PW'(1) << (sh - 1))) >> sh;
    lim = (PW'(1) << (W - 1)) - PW'(!neg);
    r.fl = (m > lim);
    if (m > lim) begin
      m = lim;
    end
    r.val = neg ? W'(-m) : W'(m);
    return r;
  endfunction

  // Configuration registers and the derived coefficient h.
  logic [bpp_pkg::FIELD_W-1:0]  qm_r;
  logic [bpp_pkg::CFG_DT_W-1:0] dt_r;
  logic [W-1:0]                 h_r;
  logic                         h_fl_r;
  logic                         hold_r;
  logic                         cfg_fire;
  res_t                         h_nxt;

  assign cfg_ch.ready = 1'b1;
  assign cfg_fire     = cfg_ch.valid & cfg_ch.ready;
  assign h_nxt        = fm(AW'($signed(qm_r)), AW'(dt_r), F + 1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qm_r   <= 32'd65536;
      dt_r   <= 31'd655;
      hold_r <= 1'b0;
    end else begin
      hold_r <= cfg_fire;
      if (cfg_fire) begin
        unique case (cfg_ch.idx)
          bpp_pkg::CFG_QM: qm_r <= cfg_ch.data;
          bpp_pkg::CFG_DT: dt_r <= cfg_ch.data[bpp_pkg::CFG_DT_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    h_r    <= h_nxt.val;
    h_fl_r <= h_nxt.fl;
  end

  // Pipeline control.
  logic [D-1:0] vld_r, vld_nxt;
  logic         en, in_fire, out_fire;

  assign en          = !vld_r[D-1] || out_ch.ready;
  assign in_ch.ready = en && !hold_r && !cfg_ch.valid;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_fire    = out_ch.valid && out_ch.ready;
  assign vld_nxt     = {vld_r[D-2:0], in_fire};
  assign out_ch.valid = vld_r[D-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= vld_nxt;
    end
  end

  rec_t s0_r, s1_r, s2_r, s3_r, s4_r, sf_r, ss_r, sc_r, sv_r, sd_r;
  rec_t s0_nxt, s1_nxt, s2_nxt, s3_nxt, s4_nxt, sf_nxt, ss_nxt, sc_nxt, sv_nxt, sd_nxt;
  rec_t div_r [QW];
  rec_t div_nxt [QW];
  bpp_pkg::out_item_t out_r, out_nxt;

  // Stage 0: saturate the inputs to the working word.
  always_comb begin
    logic [11:0][bpp_pkg::FIELD_W-1:0] raw;
    res_t r;
    s0_nxt = '0;
    raw = {in_ch.item.vel_x, in_ch.item.vel_y, in_ch.item.vel_z,
           in_ch.item.pos_x, in_ch.item.pos_y, in_ch.item.pos_z,
           in_ch.item.efield_x, in_ch.item.efield_y, in_ch.item.efield_z,
           in_ch.item.bfield_x, in_ch.item.bfield_y, in_ch.item.bfield_z};
    for (int i = 0; i < 3; i++) begin
      r = clampw(64'($signed(raw[11 - i])));
      s0_nxt.v[i] = r.val;   s0_nxt.sat |= r.fl;
      r = clampw(64'($signed(raw[8 - i])));
      s0_nxt.pos[i] = r.val; s0_nxt.sat |= r.fl;
      r = clampw(64'($signed(raw[5 - i])));
      s0_nxt.ek[i] = r.val;  s0_nxt.sat |= r.fl;
      r = clampw(64'($signed(raw[2 - i])));
      s0_nxt.tv[i] = r.val;  s0_nxt.sat |= r.fl;
    end
  end

  // Stage 1: half kick ek = h*E and t = h*B.
  always_comb begin
    res_t r;
    s1_nxt = s0_r;
    s1_nxt.sat = s0_r.sat | h_fl_r;
    for (int i = 0; i < 3; i++) begin
      r = fm(ax(s0_r.ek[i]), ax(h_r), F);
      s1_nxt.ek[i] = r.val; s1_nxt.sat |= r.fl;
      r = fm(ax(s0_r.tv[i]), ax(h_r), F);
      s1_nxt.tv[i] = r.val; s1_nxt.sat |= r.fl;
    end
  end

  // Stage 2: v minus = v + ek, and the squares of t.
  always_comb begin
    res_t r;
    s2_nxt = s1_r;
    for (int i = 0; i < 3; i++) begin
      r = clampw(sx(s1_r.v[i]) + sx(s1_r.ek[i]));
      s2_nxt.v[i] = r.val; s2_nxt.sat |= r.fl;
      r = fm(ax(s1_r.tv[i]), ax(s1_r.tv[i]), F);
      s2_nxt.pa[i] = r.val; s2_nxt.sat |= r.fl;
    end
  end

  // Stage 3: |t|^2 and the products of v minus cross t.
  always_comb begin
    res_t r;
    s3_nxt = s2_r;
    r = clampw(sx(s2_r.pa[0]) + sx(s2_r.pa[1]));
    s3_nxt.sat |= r.fl;
    r = clampw(sx(r.val) + sx(s2_r.pa[2]));
    s3_nxt.tt = r.val; s3_nxt.sat |= r.fl;
    for (int i = 0; i < 3; i++) begin
      r = fm(ax(s2_r.v[(i + 1) % 3]), ax(s2_r.tv[(i + 2) % 3]), F);
      s3_nxt.pa[i] = r.val; s3_nxt.sat |= r.fl;
      r = fm(ax(s2_r.v[(i + 2) % 3]), ax(s2_r.tv[(i + 1) % 3]), F);
      s3_nxt.pb[i] = r.val; s3_nxt.sat |= r.fl;
    end
  end

  // Stage 4: v prime, and the divider operands with round-half-up offset.
  always_comb begin
    res_t r;
    logic [DW-1:0] dn;
    s4_nxt = s3_r;
    dn = (DW'(1) << F) + DW'(s3_r.tt);
    s4_nxt.den = dn;
    s4_nxt.rem = (DW'(1) << (2 * F + 1)) + (dn >> 1);
    s4_nxt.quo = '0;
    for (int i = 0; i < 3; i++) begin
      r = clampw(sx(s3_r.pa[i]) - sx(s3_r.pb[i]));
      s4_nxt.sat |= r.fl;
      r = clampw(sx(s3_r.v[i]) + sx(r.val));
      s4_nxt.vp[i] = r.val; s4_nxt.sat |= r.fl;
    end
  end

  // Restoring divider, one quotient bit per stage, most significant first.
  always_comb begin
    rec_t src;
    logic [DW-1:0] ds;
    for (int i = 0; i < QW; i++) begin
      src = (i == 0) ? s4_r : div_r[(i == 0) ? 0 : i - 1];
      ds  = src.den << (QW - 1 - i);
      div_nxt[i] = src;
      if (src.rem >= ds) begin
        div_nxt[i].rem = src.rem - ds;
        div_nxt[i].quo[QW - 1 - i] = 1'b1;
      end
    end
  end

  // Saturate the factor f = 2/(1+|t|^2).
  always_comb begin
    res_t r;
    sf_nxt = div_r[QW-1];
    r = clampw(64'(div_r[QW-1].quo));
    sf_nxt.f = r.val;
    sf_nxt.sat |= r.fl;
  end

  // s = t*f.
  always_comb begin
    res_t r;
    ss_nxt = sf_r;
    for (int i = 0; i < 3; i++) begin
      r = fm(ax(sf_r.tv[i]), ax(sf_r.f), F);
      ss_nxt.s[i] = r.val; ss_nxt.sat |= r.fl;
    end
  end

  // Products of v prime cross s.
  always_comb begin
    res_t r;
    sc_nxt = ss_r;
    for (int i = 0; i < 3; i++) begin
      r = fm(ax(ss_r.vp[(i + 1) % 3]), ax(ss_r.s[(i + 2) % 3]), F);
      sc_nxt.pa[i] = r.val; sc_nxt.sat |= r.fl;
      r = fm(ax(ss_r.vp[(i + 2) % 3]), ax(ss_r.s[(i + 1) % 3]), F);
      sc_nxt.pb[i] = r.val; sc_nxt.sat |= r.fl;
    end
  end

  // New velocity: v minus plus rotation, then the second half kick.
  always_comb begin
    res_t r;
    sv_nxt = sc_r;
    for (int i = 0; i < 3; i++) begin
      r = clampw(sx(sc_r.pa[i]) - sx(sc_r.pb[i]));
      sv_nxt.sat |= r.fl;
      r = clampw(sx(sc_r.v[i]) + sx(r.val));
      sv_nxt.sat |= r.fl;
      r = clampw(sx(r.val) + sx(sc_r.ek[i]));
      sv_nxt.v[i] = r.val; sv_nxt.sat |= r.fl;
    end
  end

  // Drift product v_new * dt.
  always_comb begin
    res_t r;
    sd_nxt = sv_r;
    for (int i = 0; i < 3; i++) begin
      r = fm(ax(sv_r.v[i]), AW'(dt_r), F);
      sd_nxt.pa[i] = r.val; sd_nxt.sat |= r.fl;
    end
  end

  // New position and clipping to the output fields.
  always_comb begin
    res_t  r;
    ores_t o;
    logic  fl;
    logic [2:0][bpp_pkg::FIELD_W-1:0] nv, np;
    fl = sd_r.sat;
    for (int i = 0; i < 3; i++) begin
      r = clampw(sx(sd_r.pos[i]) + sx(sd_r.pa[i]));
      fl |= r.fl;
      o = clamp32(sd_r.v[i]);
      nv[i] = o.val; fl |= o.fl;
      o = clamp32(r.val);
      np[i] = o.val; fl |= o.fl;
    end
    out_nxt.new_vel_x = nv[0];
    out_nxt.new_vel_y = nv[1];
    out_nxt.new_vel_z = nv[2];
    out_nxt.new_pos_x = np[0];
    out_nxt.new_pos_y = np[1];
    out_nxt.new_pos_z = np[2];
    out_nxt.saturated = fl;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_r  <= s0_nxt;
      s1_r  <= s1_nxt;
      s2_r  <= s2_nxt;
      s3_r  <= s3_nxt;
      s4_r  <= s4_nxt;
      for (int i = 0; i < QW; i++) begin
        div_r[i] <= div_nxt[i];
      end
      sf_r  <= sf_nxt;
      ss_r  <= ss_nxt;
      sc_r  <= sc_nxt;
      sv_r  <= sv_nxt;
      sd_r  <= sd_nxt;
      out_r <= out_nxt;
    end
  end

  assign out_ch.item = out_r;

  // Items in flight, for checking the valid chain.
  logic [CW-1:0] cnt_r, cnt_nxt;
  assign cnt_nxt = cnt_r + CW'(in_fire) - CW'(out_fire);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  `BPP_ASSERT_NEXT(a_cfg_blocks_input, clk, rst_n, cfg_fire, !in_ch.ready)
  `BPP_ASSERT(a_out_has_item, clk, rst_n, out_ch.valid, cnt_r != '0)
  `BPP_ASSERT(a_count_matches, clk, rst_n, 1'b1, cnt_r == CW'($countones(vld_r)))

endmodule

`default_nettype wire

// ----- sim/boris_particle_push_tb.sv -----
// Self-checking testbench for boris_particle_push: particles are streamed over the
// valid/ready channels and each result is checked against a fixed-point Boris step.
// Depends on bpp_pkg, the channel interfaces and the RTL top level.
`timescale 1ns / 1ps

module boris_particle_push_tb;

  typedef longint vec3_t [3];

  typedef struct {
    bpp_pkg::in_item_t  it;
    bit                 typed;
    bpp_pkg::out_item_t want;
  } stim_row_t;

  localparam longint WORD_MAX = 64'sd2147483647;
  localparam longint WORD_MIN = -64'sd2147483648;
  localparam int     CYCLE_LIMIT = 400000;
  localparam int     DRAIN_CYCLES = 60;

  logic clk;
  logic rst_n;

  bpp_in_if  in_ch ();
  bpp_out_if out_ch ();
  bpp_cfg_if cfg_ch ();

  boris_particle_push uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  logic signed [31:0] qm_shadow;
  logic [30:0]        dt_shadow;
  bpp_pkg::out_item_t pending_results[$];
  int                 err_count;
  int                 cycle_count;
  int                 src_idle_pct;
  int                 snk_idle_pct;
  stim_row_t          stim_table[$];

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic longint sat_word(longint x, inout bit clip);
    if (x > WORD_MAX) begin
      clip = 1'b1;
      return WORD_MAX;
    end
    if (x < WORD_MIN) begin
      clip = 1'b1;
      return WORD_MIN;
    end
    return x;
  endfunction

  // Product rounded to nearest (ties away from zero), shifted and saturated.
  function automatic longint mul_round(longint a, longint b, int sh, inout bit clip);
    bit          neg;
    logic [127:0] ma, mb, prod, lim;
    neg  = (a < 0) != (b < 0);
    ma   = 128'(a < 0 ? -a : a);
    mb   = 128'(b < 0 ? -b : b);
    prod = (ma * mb + (128'd1 << (sh - 1))) >> sh;
    lim  = (128'd1 << 31) - (neg ? 128'd0 : 128'd1);
    if (prod > lim) begin
      clip = 1'b1;
      prod = lim;
    end
    return neg ? -longint'(prod[63:0]) : longint'(prod[63:0]);
  endfunction

  function automatic vec3_t cross_sat(vec3_t a, vec3_t b, inout bit clip);
    vec3_t r;
    r[0] = sat_word(mul_round(a[1], b[2], 16, clip) - mul_round(a[2], b[1], 16, clip), clip);
    r[1] = sat_word(mul_round(a[2], b[0], 16, clip) - mul_round(a[0], b[2], 16, clip), clip);
    r[2] = sat_word(mul_round(a[0], b[1], 16, clip) - mul_round(a[1], b[0], 16, clip), clip);
    return r;
  endfunction

  function automatic bpp_pkg::out_item_t boris_step(bpp_pkg::in_item_t it,
                                                    logic signed [31:0] qm,
                                                    logic [30:0] dt);
    bit                 clip;
    vec3_t              vel, pos, ef, bf, kick, vminus, tvec, svec, rot, vprime, vnew, pnew;
    longint             coef, tsq, fac, dtl;
    longint             den, num;
    bpp_pkg::out_item_t r;
    clip = 1'b0;
    dtl  = longint'(dt);
    vel  = '{longint'(it.vel_x), longint'(it.vel_y), longint'(it.vel_z)};
    pos  = '{longint'(it.pos_x), longint'(it.pos_y), longint'(it.pos_z)};
    ef   = '{longint'(it.efield_x), longint'(it.efield_y), longint'(it.efield_z)};
    bf   = '{longint'(it.bfield_x), longint'(it.bfield_y), longint'(it.bfield_z)};
    coef = mul_round(longint'(qm), dtl, 17, clip);
    tsq  = 0;
    for (int i = 0; i < 3; i++) begin
      kick[i]   = mul_round(ef[i], coef, 16, clip);
      vminus[i] = sat_word(vel[i] + kick[i], clip);
      tvec[i]   = mul_round(bf[i], coef, 16, clip);
    end
    for (int i = 0; i < 3; i++)
      tsq = sat_word(tsq + mul_round(tvec[i], tvec[i], 16, clip), clip);
    den = 65536 + tsq;
    num = 64'd1 << 33;
    fac = sat_word((num + den / 2) / den, clip);
    for (int i = 0; i < 3; i++) svec[i] = mul_round(tvec[i], fac, 16, clip);
    rot = cross_sat(vminus, tvec, clip);
    for (int i = 0; i < 3; i++) vprime[i] = sat_word(vminus[i] + rot[i], clip);
    rot = cross_sat(vprime, svec, clip);
    for (int i = 0; i < 3; i++) begin
      vnew[i] = sat_word(sat_word(vminus[i] + rot[i], clip) + kick[i], clip);
      pnew[i] = sat_word(pos[i] + mul_round(vnew[i], dtl, 16, clip), clip);
    end
    r.new_vel_x = vnew[0][31:0];
    r.new_vel_y = vnew[1][31:0];
    r.new_vel_z = vnew[2][31:0];
    r.new_pos_x = pnew[0][31:0];
    r.new_pos_y = pnew[1][31:0];
    r.new_pos_z = pnew[2][31:0];
    r.saturated = clip;
    return r;
  endfunction

  function automatic logic [31:0] small_val();
    return 32'($signed($urandom) >>> $urandom_range(24, 8));
  endfunction

  function automatic bpp_pkg::in_item_t random_particle();
    bpp_pkg::in_item_t it;
    if ($urandom_range(3) == 0) begin
      it = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
            $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    end else begin
      // Physically sized particles keep most steps clear of saturation.
      it = {small_val(), small_val(), small_val(), $urandom, $urandom, $urandom,
            small_val(), small_val(), small_val(), small_val(), small_val(), small_val()};
    end
    return it;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %h, actual %h", name, want, got);
      err_count++;
    end
  endtask

  // Result checker; outputs are sampled at the rising edge.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result transfer");
        err_count++;
      end else begin
        bpp_pkg::out_item_t w;
        w = pending_results.pop_front();
        check_field("new_vel_x", w.new_vel_x, out_ch.item.new_vel_x);
        check_field("new_vel_y", w.new_vel_y, out_ch.item.new_vel_y);
        check_field("new_vel_z", w.new_vel_z, out_ch.item.new_vel_z);
        check_field("new_pos_x", w.new_pos_x, out_ch.item.new_pos_x);
        check_field("new_pos_y", w.new_pos_y, out_ch.item.new_pos_y);
        check_field("new_pos_z", w.new_pos_z, out_ch.item.new_pos_z);
        check_field("saturated", 32'(w.saturated), 32'(out_ch.item.saturated));
      end
    end
  end

  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic send_particle(bpp_pkg::in_item_t it, bit typed, bpp_pkg::out_item_t want);
    @(negedge clk);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.item  <= it;
    do @(posedge clk); while (!in_ch.ready);
    pending_results.push_back(typed ? want : boris_step(it, qm_shadow, dt_shadow));
  endtask

  task automatic write_reg(bpp_pkg::cfg_idx_t idx, logic [31:0] data);
    @(negedge clk);
    in_ch.valid  <= 1'b0;
    cfg_ch.valid <= 1'b1;
    cfg_ch.idx   <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    if (idx == bpp_pkg::CFG_QM) qm_shadow = data;
    else dt_shadow = data[30:0];
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic stim_row_t make_row(bpp_pkg::in_item_t it);
    stim_row_t r;
    r.it    = it;
    r.typed = 1'b0;
    r.want  = '0;
    return r;
  endfunction

  function automatic stim_row_t make_still(logic [31:0] px, logic [31:0] py,
                                           logic [31:0] pz);
    stim_row_t r;
    // No velocity and no field: the particle stays where it is.
    r.it    = '0;
    r.it.pos_x = px;
    r.it.pos_y = py;
    r.it.pos_z = pz;
    r.typed = 1'b1;
    r.want  = '0;
    r.want.new_pos_x = px;
    r.want.new_pos_y = py;
    r.want.new_pos_z = pz;
    return r;
  endfunction

  task automatic build_table();
    bpp_pkg::in_item_t it;
    stim_table.push_back(make_still(32'h0, 32'h0, 32'h0));
    stim_table.push_back(make_still(32'h7fffffff, 32'h80000000, 32'h00010000));
    stim_table.push_back(make_still(32'h80000000, 32'h7fffffff, 32'hffff0000));
    it = '0;
    it.vel_x = 32'h7fffffff; it.vel_y = 32'h80000000; it.vel_z = 32'h00010000;
    stim_table.push_back(make_row(it));
    it.pos_x = 32'h7fffffff; it.pos_y = 32'h80000000;
    stim_table.push_back(make_row(it));
    it = '0;
    it.efield_x = 32'h7fffffff; it.efield_y = 32'h80000000; it.efield_z = 32'h00020000;
    stim_table.push_back(make_row(it));
    it = '0;
    it.vel_x = 32'h00010000;
    it.bfield_z = 32'h7fffffff;
    stim_table.push_back(make_row(it));
    it.bfield_z = 32'h80000000;
    stim_table.push_back(make_row(it));
    it = '0;
    it.vel_y = 32'h00030000; it.bfield_x = 32'h00640000; it.bfield_y = 32'hff9c0000;
    stim_table.push_back(make_row(it));
    stim_table.push_back(make_row({12{32'h7fffffff}}));
    stim_table.push_back(make_row({12{32'h80000000}}));
    stim_table.push_back(make_row({12{32'hffffffff}}));
    stim_table.push_back(make_row({12{32'h00000001}}));
    it = '0;
    it.vel_x = 32'h00008000; it.vel_z = 32'hffff8000;
    it.efield_y = 32'h00010000; it.bfield_z = 32'h00010000;
    stim_table.push_back(make_row(it));
    it = {32'h00020000, 32'hfffe0000, 32'h00004000, 32'h00100000, 32'hfff00000,
          32'h0, 32'h00050000, 32'h0, 32'hfffb0000, 32'h000a0000, 32'h00140000,
          32'hfff60000};
    stim_table.push_back(make_row(it));
  endtask

  initial begin
    logic signed [31:0] qm_set [6];
    logic [30:0]        dt_set [6];
    bpp_pkg::in_item_t  it;

    err_count    = 0;
    cycle_count  = 0;
    src_idle_pct = 28;
    snk_idle_pct = 84;
    qm_shadow    = 32'sd65536;
    dt_shadow    = 31'd655;
    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.item   = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.idx   = bpp_pkg::CFG_QM;
    cfg_ch.data  = '0;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    build_table();
    foreach (stim_table[i])
      send_particle(stim_table[i].it, stim_table[i].typed, stim_table[i].want);
    wait_idle();

    qm_set[0] = 32'h80000000;  dt_set[0] = 31'h7fffffff;
    qm_set[1] = 32'h7fffffff;  dt_set[1] = 31'd1;
    qm_set[2] = 32'h0;         dt_set[2] = 31'h40000000;
    qm_set[3] = 32'($urandom_range(1 << 19) - (1 << 18));
    dt_set[3] = 31'($urandom_range(65536, 1));
    qm_set[4] = -32'sd65536;   dt_set[4] = 31'd6554;
    qm_set[5] = $urandom;      dt_set[5] = 31'($urandom_range(32'h7fffffff, 1));

    for (int ph = 0; ph < 6; ph++) begin
      case (ph / 2)
        0: begin
          src_idle_pct = 28;
          snk_idle_pct = 84;
        end
        1: begin
          src_idle_pct = 84;
          snk_idle_pct = 28;
        end
        default: begin
          src_idle_pct = 0;
          snk_idle_pct = 0;
        end
      endcase
      write_reg(bpp_pkg::CFG_QM, qm_set[ph]);
      write_reg(bpp_pkg::CFG_DT, {1'b0, dt_set[ph]});
      for (int n = 0; n < 275; n++) begin
        it = random_particle();
        send_particle(it, 1'b0, '0);
      end
      wait_idle();
    end

    if (err_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/bpp_pkg.sv
rtl/bpp_ifs.sv
rtl/boris_particle_push.sv
sim/boris_particle_push_tb.sv
